// ===== design/ffd_pkg.sv =====
// shared constants and types for the fractional feedback delay
package ffd_pkg;

  localparam int MEMORY_DEPTH = 65536;
  localparam int SAMPLE_BITS  = 24;
  localparam int MEM_ENTRIES  = MEMORY_DEPTH + 1;
  localparam int ADDR_BITS    = $clog2(MEM_ENTRIES);
  localparam int FRAC_BITS    = 16;
  localparam int POS_BITS     = ADDR_BITS + FRAC_BITS;

  localparam int SPM_BITS  = 24;
  localparam int LEN_BITS  = 17;
  localparam int MS_BITS   = 20;
  localparam int GAIN_BITS = 16;
  localparam int DAMP_BITS = 16;
  localparam int FILT_BITS = 32;
  localparam int COEF_BITS = 17;
  localparam int DLY_BITS  = MS_BITS + SPM_BITS - 8;

  localparam int MUL_A_BITS = 33;
  localparam int MUL_B_BITS = 25;
  localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;

  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 24;

  localparam logic [CFG_IDX_BITS-1:0] REG_SAMPLES_PER_MS = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE_LENGTH  = CFG_IDX_BITS'(1);

  localparam logic [SPM_BITS-1:0] SPM_RESET = SPM_BITS'(2890138);
  localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(44101);
  localparam int LEN_MIN  = 16;
  localparam int DAMP_MAX = 64880;
  localparam int DLY_MIN  = 3 << FRAC_BITS;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DLY,
    ST_POS,
    ST_ADDR,
    ST_RD1,
    ST_M1,
    ST_Y,
    ST_F,
    ST_FB,
    ST_W,
    ST_WRAP
  } state_t;

endpackage

// ===== design/fractional_feedback_delay.sv =====
// fractional feedback delay top level: sequencer, datapath and sample store
// an accepted transaction steps through DLY, POS, ADDR, RD1, M1, Y, F, FB and W (then WRAP
// when the write position wraps), paced by the single shared multiplier; in_stall stays high
// until IDLE; the result register loads in state Y, which waits while it is still full
// after reset the store is cleared one entry a cycle, all 65537 entries, with in_stall high;
// configuration registers take their reset values at once and accept writes throughout
module fractional_feedback_delay (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic signed [ffd_pkg::SAMPLE_BITS-1:0]    in_sample_in,
  input  logic [ffd_pkg::MS_BITS-1:0]               in_delay_ms,
  input  logic signed [ffd_pkg::GAIN_BITS-1:0]      in_feedback_gain,
  input  logic [ffd_pkg::DAMP_BITS-1:0]             in_damping_amount,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [ffd_pkg::SAMPLE_BITS-1:0]    out_sample_out,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [ffd_pkg::CFG_IDX_BITS-1:0]          cfg_index,
  input  logic [ffd_pkg::CFG_DATA_BITS-1:0]         cfg_data
);
  import ffd_pkg::*;

  // saturation bounds at product width
  localparam logic signed [MUL_P_BITS-1:0] SMAX_P =
    MUL_P_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [MUL_P_BITS-1:0] SMIN_P = -SMAX_P - MUL_P_BITS'(1);
  localparam logic signed [MUL_P_BITS-1:0] FMAX_P =
    MUL_P_BITS'((64'sd1 <<< (FILT_BITS - 1)) - 64'sd1);
  localparam logic signed [MUL_P_BITS-1:0] FMIN_P = -FMAX_P - MUL_P_BITS'(1);
  localparam logic signed [MUL_P_BITS-1:0] HALF16 = MUL_P_BITS'(32768);
  localparam logic signed [MUL_P_BITS-1:0] HALF15 = MUL_P_BITS'(16384);

  // control state
  state_t                  state_r, state_nxt;
  logic [ADDR_BITS-1:0]    clr_r, clr_nxt;
  logic [SPM_BITS-1:0]     spm_r, spm_nxt;
  logic [LEN_BITS-1:0]     len_cfg_r, len_cfg_nxt;
  logic [ADDR_BITS-1:0]    wp_r, wp_nxt;
  logic signed [FILT_BITS-1:0] fm_r, fm_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // per-transaction datapath registers
  logic signed [SAMPLE_BITS-1:0] x_r, x_nxt;
  logic [MS_BITS-1:0]            ms_r, ms_nxt;
  logic signed [GAIN_BITS-1:0]   fb_r, fb_nxt;
  logic [DAMP_BITS-1:0]          damp_r, damp_nxt;
  logic [ADDR_BITS-1:0]          len_r, len_nxt;
  logic [POS_BITS-1:0]           dly_r, dly_nxt;
  logic [ADDR_BITS-1:0]          idx_r, idx_nxt;
  logic [FRAC_BITS-1:0]          mu_r, mu_nxt;
  logic [COEF_BITS-1:0]          c_r, c_nxt;
  logic signed [MUL_P_BITS-1:0]  acc_r, acc_nxt;
  logic signed [SAMPLE_BITS-1:0] y_r, y_nxt;
  logic signed [FILT_BITS-1:0]   f_r, f_nxt;
  logic signed [SAMPLE_BITS-1:0] w_r, w_nxt;
  logic signed [SAMPLE_BITS-1:0] out_sample_r, out_sample_nxt;

  // shared multiplier and store
  logic                          mul_en;
  logic signed [MUL_A_BITS-1:0]  mul_a;
  logic signed [MUL_B_BITS-1:0]  mul_b;
  logic signed [MUL_P_BITS-1:0]  prod;
  logic                          ram_we;
  logic [ADDR_BITS-1:0]          ram_waddr;
  logic [SAMPLE_BITS-1:0]        ram_wdata;
  logic [ADDR_BITS-1:0]          ram_raddr;
  logic [SAMPLE_BITS-1:0]        ram_rdata;

  // combinational helpers
  logic                          in_take;
  logic                          out_free;
  logic [ADDR_BITS-1:0]          len_c;
  logic [DLY_BITS-1:0]           dly_full;
  logic [POS_BITS-1:0]           dly_hi;
  logic signed [POS_BITS:0]      r_diff;
  logic signed [POS_BITS:0]      r_pos;
  logic signed [GAIN_BITS+1:0]   fb_comp_s;
  logic [COEF_BITS-1:0]          fb_comp;
  logic [FRAC_BITS:0]            w0;
  logic signed [SAMPLE_BITS-1:0] rd_s;
  logic signed [MUL_P_BITS-1:0]  y_sum;
  logic signed [MUL_P_BITS-1:0]  f_sum;
  logic signed [MUL_P_BITS-1:0]  w_sum;

  ffd_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  ffd_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MEM_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall       = (state_r != ST_IDLE);
  assign in_take        = in_valid && !in_stall;
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign cfg_ready      = 1'b1;
  // output register can take a new result this cycle
  assign out_free       = !out_valid_r || !out_stall;

  // ring length in use, clamped to the legal span
  always_comb begin
    if (32'(len_cfg_r) < LEN_MIN) begin
      len_c = ADDR_BITS'(LEN_MIN);
    end else if (32'(len_cfg_r) > MEMORY_DEPTH) begin
      len_c = ADDR_BITS'(MEMORY_DEPTH);
    end else begin
      len_c = ADDR_BITS'(len_cfg_r);
    end
  end

  // delay in Q.16 samples and its upper bound
  assign dly_full = prod[MS_BITS+SPM_BITS-1:8];
  assign dly_hi   = {len_r - ADDR_BITS'(1), {FRAC_BITS{1'b0}}};

  // read position behind the write pointer, folded into the ring
  assign r_diff = $signed({1'b0, wp_r, {FRAC_BITS{1'b0}}}) - $signed({1'b0, dly_r});
  always_comb begin
    if (r_diff < 0) begin
      r_pos = r_diff + $signed({1'b0, len_r, {FRAC_BITS{1'b0}}});
    end else begin
      r_pos = r_diff;
    end
  end

  // 1 - feedback in Q.15, always above 0 and at most 2
  assign fb_comp_s = $signed((GAIN_BITS+2)'(32768)) - (GAIN_BITS+2)'(fb_r);
  assign fb_comp   = fb_comp_s[COEF_BITS-1:0];
  // weight of the older tap
  assign w0        = (FRAC_BITS+1)'(1 << FRAC_BITS) - (FRAC_BITS+1)'(mu_r);
  assign rd_s      = $signed(ram_rdata);

  // rounded sums, floor shifts on the signed product
  assign y_sum = (acc_r + prod + HALF16) >>> FRAC_BITS;
  assign f_sum = MUL_P_BITS'(y_r) + ((prod + HALF16) >>> FRAC_BITS);
  assign w_sum = MUL_P_BITS'(x_r) + ((prod + HALF15) >>> 15);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      spm_r       <= SPM_RESET;
      len_cfg_r   <= LEN_RESET;
      wp_r        <= '0;
      fm_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      spm_r       <= spm_nxt;
      len_cfg_r   <= len_cfg_nxt;
      wp_r        <= wp_nxt;
      fm_r        <= fm_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    ms_r         <= ms_nxt;
    fb_r         <= fb_nxt;
    damp_r       <= damp_nxt;
    len_r        <= len_nxt;
    dly_r        <= dly_nxt;
    idx_r        <= idx_nxt;
    mu_r         <= mu_nxt;
    c_r          <= c_nxt;
    acc_r        <= acc_nxt;
    y_r          <= y_nxt;
    f_r          <= f_nxt;
    w_r          <= w_nxt;
    out_sample_r <= out_sample_nxt;
  end

  // sequencer: next state, datapath updates, multiplier and store control
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    spm_nxt        = spm_r;
    len_cfg_nxt    = len_cfg_r;
    wp_nxt         = wp_r;
    fm_nxt         = fm_r;
    out_valid_nxt  = out_valid_r;
    x_nxt          = x_r;
    ms_nxt         = ms_r;
    fb_nxt         = fb_r;
    damp_nxt       = damp_r;
    len_nxt        = len_r;
    dly_nxt        = dly_r;
    idx_nxt        = idx_r;
    mu_nxt         = mu_r;
    c_nxt          = c_r;
    acc_nxt        = acc_r;
    y_nxt          = y_r;
    f_nxt          = f_r;
    w_nxt          = w_r;
    out_sample_nxt = out_sample_r;
    mul_en         = 1'b0;
    mul_a          = '0;
    mul_b          = '0;
    ram_we         = 1'b0;
    ram_waddr      = wp_r;
    ram_wdata      = w_nxt;
    ram_raddr      = idx_r;

    // result leaves the output register
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // configuration writes, unknown indexes dropped
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SAMPLES_PER_MS: spm_nxt = cfg_data[SPM_BITS-1:0];
        REG_ACTIVE_LENGTH:  len_cfg_nxt = cfg_data[LEN_BITS-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_CLEAR: begin
        // zero the store one entry a cycle
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + ADDR_BITS'(1);
        if (clr_r == ADDR_BITS'(MEM_ENTRIES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_take) begin
          x_nxt    = in_sample_in;
          ms_nxt   = in_delay_ms;
          fb_nxt   = in_feedback_gain;
          damp_nxt = (32'(in_damping_amount) > DAMP_MAX) ?
                     DAMP_BITS'(DAMP_MAX) : in_damping_amount;
          len_nxt  = len_c;
          // ring shrunk below the write pointer: restart at the first slot
          if (wp_r > len_c) begin
            wp_nxt = ADDR_BITS'(1);
          end
          state_nxt = ST_DLY;
        end
      end
      ST_DLY: begin
        // milliseconds to samples
        mul_en    = 1'b1;
        mul_a     = $signed(MUL_A_BITS'(spm_r));
        mul_b     = $signed(MUL_B_BITS'(ms_r));
        state_nxt = ST_POS;
      end
      ST_POS: begin
        if (64'(dly_full) < 64'(DLY_MIN)) begin
          dly_nxt = POS_BITS'(DLY_MIN);
        end else if (64'(dly_full) > 64'(dly_hi)) begin
          dly_nxt = dly_hi;
        end else begin
          dly_nxt = dly_full[POS_BITS-1:0];
        end
        // damping coefficient product
        mul_en    = 1'b1;
        mul_a     = $signed(MUL_A_BITS'(fb_comp));
        mul_b     = $signed(MUL_B_BITS'(damp_r));
        state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        c_nxt     = prod[15 +: COEF_BITS];
        idx_nxt   = r_pos[FRAC_BITS +: ADDR_BITS];
        mu_nxt    = r_pos[FRAC_BITS-1:0];
        ram_raddr = r_pos[FRAC_BITS +: ADDR_BITS];
        state_nxt = ST_RD1;
      end
      ST_RD1: begin
        // older tap arrives, fetch the newer one
        ram_raddr = idx_r + ADDR_BITS'(1);
        mul_en    = 1'b1;
        mul_a     = MUL_A_BITS'(rd_s);
        mul_b     = $signed(MUL_B_BITS'(w0));
        state_nxt = ST_M1;
      end
      ST_M1: begin
        acc_nxt   = prod;
        mul_en    = 1'b1;
        mul_a     = MUL_A_BITS'(rd_s);
        mul_b     = $signed(MUL_B_BITS'(mu_r));
        state_nxt = ST_Y;
      end
      ST_Y: begin
        // hold here until the output register is free
        if (out_free) begin
          if (y_sum > SMAX_P) begin
            y_nxt = SAMPLE_BITS'(SMAX_P);
          end else if (y_sum < SMIN_P) begin
            y_nxt = SAMPLE_BITS'(SMIN_P);
          end else begin
            y_nxt = SAMPLE_BITS'(y_sum);
          end
          out_sample_nxt = y_nxt;
          out_valid_nxt  = 1'b1;
          mul_en         = 1'b1;
          mul_a          = MUL_A_BITS'(fm_r);
          mul_b          = $signed(MUL_B_BITS'(c_r));
          state_nxt      = ST_F;
        end
      end
      ST_F: begin
        // one-pole damping filter
        if (f_sum > FMAX_P) begin
          f_nxt = FILT_BITS'(FMAX_P);
        end else if (f_sum < FMIN_P) begin
          f_nxt = FILT_BITS'(FMIN_P);
        end else begin
          f_nxt = FILT_BITS'(f_sum);
        end
        fm_nxt    = f_nxt;
        state_nxt = ST_FB;
      end
      ST_FB: begin
        mul_en    = 1'b1;
        mul_a     = MUL_A_BITS'(f_r);
        mul_b     = MUL_B_BITS'(fb_r);
        state_nxt = ST_W;
      end
      ST_W: begin
        if (w_sum > SMAX_P) begin
          w_nxt = SAMPLE_BITS'(SMAX_P);
        end else if (w_sum < SMIN_P) begin
          w_nxt = SAMPLE_BITS'(SMIN_P);
        end else begin
          w_nxt = SAMPLE_BITS'(w_sum);
        end
        ram_we    = 1'b1;
        ram_waddr = wp_r;
        ram_wdata = w_nxt;
        // last slot written: wrap and mirror it into entry zero
        if (wp_r == len_r) begin
          wp_nxt    = ADDR_BITS'(1);
          state_nxt = ST_WRAP;
        end else begin
          wp_nxt    = wp_r + ADDR_BITS'(1);
          state_nxt = ST_IDLE;
        end
      end
      ST_WRAP: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = w_r;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/ffd_ram.sv =====
// generic single write port ram with registered read
module ffd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/ffd_mul.sv =====
// shared signed multiplier with registered product
module ffd_mul (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [ffd_pkg::MUL_A_BITS-1:0] a,
  input  logic signed [ffd_pkg::MUL_B_BITS-1:0] b,
  output logic signed [ffd_pkg::MUL_P_BITS-1:0] p
);
  import ffd_pkg::*;

  logic signed [MUL_P_BITS-1:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= MUL_P_BITS'(a) * MUL_P_BITS'(b);
    end
  end

  assign p = p_r;

endmodule
